>>> hdl/bal_pkg.sv
package bal_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned REQ_W = 3;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned GROUP_W = 32;
  localparam int unsigned DEPTH_DEFAULT = 64;
  localparam int unsigned CAP_RESET_VAL = 64;

  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_ERASE  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd4;

  // Commands broadcast to every cell of the chain.
  localparam logic [1:0] CMD_HOLD   = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_INSERT = 2'd2;
  localparam logic [1:0] CMD_ERASE  = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]         req_type;
    logic [CNT_W-1:0]         index;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [CNT_W-1:0] index;
    logic [CNT_W-1:0] count;
  } bcast_t;

endpackage

>>> hdl/bal_cell.sv
module bal_cell #(
  parameter int unsigned POS = 0
) (
  input  logic                         clk,
  input  bal_pkg::bcast_t              bc,
  input  logic [bal_pkg::WORD_W-1:0]   value,
  input  logic [bal_pkg::WORD_W-1:0]   left,
  input  logic [bal_pkg::WORD_W-1:0]   right,
  output logic [bal_pkg::WORD_W-1:0]   q,
  output logic [bal_pkg::WORD_W-1:0]   hit
);
  import bal_pkg::*;

  logic at_idx;
  logic above_idx;
  logic at_cnt;

  assign at_idx    = (32'(POS) == 32'(bc.index));
  assign above_idx = (32'(POS) >  32'(bc.index));
  assign at_cnt    = (32'(POS) == 32'(bc.count));

  // An insert pulls the word from the lower neighbor, an erase from the upper one.
  always_ff @(posedge clk) begin
    case (bc.cmd)
      CMD_APPEND: begin
        if (at_cnt) q <= value;
      end
      CMD_INSERT: begin
        if (at_idx) begin
          q <= value;
        end else if (above_idx) begin
          q <= left;
        end
      end
      CMD_ERASE: begin
        if (at_idx || above_idx) q <= right;
      end
      default: begin
      end
    endcase
  end

  assign hit = at_idx ? q : '0;

endmodule

>>> hdl/bal_rdgrp.sv
module bal_rdgrp (
  input  logic                                         clk,
  input  logic                                         en,
  input  logic [bal_pkg::GROUP_W-1:0][bal_pkg::WORD_W-1:0] words,
  output logic [bal_pkg::WORD_W-1:0]                   q
);
  import bal_pkg::*;

  logic [WORD_W-1:0] q_next;

  // At most one word of the group is nonzero, so an OR selects it.
  always_comb begin
    q_next = '0;
    for (int i = 0; i < GROUP_W; i++) begin
      q_next = q_next | words[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) q <= q_next;
  end

endmodule

>>> hdl/bounded_array_list.sv
// Bounded array list: an ordered list of signed 32-bit words with a live count.
// The req channel (req_valid/req_ready/req) carries one request per transaction:
// append, insert at an index, erase at an index, read at an index, or clear.
// The rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result per
// request, in order: ok, the word read (zero unless a read succeeded) and the
// count after the request. cfg_we/cfg_data write the capacity limit at once;
// the user must see that it is written only while no request is outstanding;
// the block does not enforce this. On acceptance every cell of the chain
// shifts or loads in parallel with its neighbors, so inserts and erases move the whole tail at once.
// The result passes the middle stage and then the output register; reads pass
// through a registered OR reduction over groups of 32 cells. A new request
// is accepted every cycle as long as the result side keeps taking transactions.
// When rsp_ready stays low, one result waits in the output register and one in
// the stage behind it; req_ready then drops until the output register drains.
// Synchronous reset empties the list, sets the capacity to 64 (or DEPTH if
// smaller) and discards results in flight. Cell contents are not cleared.
module bounded_array_list #(
  parameter int unsigned DEPTH = bal_pkg::DEPTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  bal_pkg::req_t              req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output bal_pkg::rsp_t              rsp,
  input  logic                       cfg_we,
  input  logic [bal_pkg::CNT_W-1:0]  cfg_data
);
  import bal_pkg::*;

  localparam int unsigned NG = (DEPTH + GROUP_W - 1) / GROUP_W;
  localparam logic [CNT_W-1:0] CAP_RESET =
    CNT_W'((DEPTH < CAP_RESET_VAL) ? DEPTH : CAP_RESET_VAL);

  // List state.
  logic [CNT_W-1:0] live_count;
  logic [CNT_W-1:0] live_count_next;
  logic [CNT_W-1:0] cap;
  logic [CNT_W-1:0] cfg_clamped;

  // Middle stage between acceptance and the output register.
  logic             s1_valid;
  logic             s1_ok;
  logic             s1_read;
  logic [CNT_W-1:0] s1_count;
  logic             s1_move;

  logic             accept;
  logic             ok;
  logic [1:0]       cmd;
  logic             room;
  bcast_t           bc;

  logic [WORD_W-1:0]                          cell_q [DEPTH];
  logic [NG*GROUP_W-1:0][WORD_W-1:0]          hits;
  logic [WORD_W-1:0]                          grp_q [NG];
  logic [WORD_W-1:0]                          rd_word;

  assign s1_move   = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !s1_valid || s1_move;
  assign accept    = req_valid && req_ready;

  // There is room while the count sits below both the capacity and the store size.
  assign room = (live_count < cap) && (32'(live_count) < DEPTH);

  // Decode the request against the current count.
  always_comb begin
    ok              = 1'b0;
    cmd             = CMD_HOLD;
    live_count_next = live_count;
    case (req.req_type)
      REQ_APPEND: begin
        ok = room;
        if (ok) begin
          cmd             = CMD_APPEND;
          live_count_next = live_count + CNT_W'(1);
        end
      end
      REQ_INSERT: begin
        ok = room && (req.index <= live_count);
        if (ok) begin
          cmd             = CMD_INSERT;
          live_count_next = live_count + CNT_W'(1);
        end
      end
      REQ_ERASE: begin
        ok = (req.index < live_count);
        if (ok) begin
          cmd             = CMD_ERASE;
          live_count_next = live_count - CNT_W'(1);
        end
      end
      REQ_READ: begin
        ok = (req.index < live_count);
      end
      REQ_CLEAR: begin
        ok              = 1'b1;
        live_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  // The cells act only on an accepted, successful request.
  assign bc.cmd   = accept ? cmd : CMD_HOLD;
  assign bc.index = req.index;
  assign bc.count = live_count;

  // Capacity writes saturate at the store size and are ignored below the count.
  assign cfg_clamped = (32'(cfg_data) > DEPTH) ? CNT_W'(DEPTH) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      live_count <= '0;
      cap        <= CAP_RESET;
    end else begin
      if (accept) live_count <= live_count_next;
      if (cfg_we && (cfg_clamped >= live_count)) cap <= cfg_clamped;
    end
  end

  // Chain of cells. Cell 0 never takes from below; the last cell keeps its own word.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] left_w;
    logic [WORD_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_inner
      assign right_w = cell_q[i+1];
    end
    bal_cell #(
      .POS(i)
    ) u_cell (
      .clk   (clk),
      .bc    (bc),
      .value (WORD_W'($unsigned(req.value))),
      .left  (left_w),
      .right (right_w),
      .q     (cell_q[i]),
      .hit   (hits[i])
    );
  end

  // Padding lanes of the last group read as zero.
  for (genvar i = DEPTH; i < NG * GROUP_W; i++) begin : g_pad
    assign hits[i] = '0;
  end

  // First level of the read reduction, registered at acceptance.
  for (genvar g = 0; g < NG; g++) begin : g_grp
    bal_rdgrp u_grp (
      .clk   (clk),
      .en    (accept),
      .words (hits[g*GROUP_W +: GROUP_W]),
      .q     (grp_q[g])
    );
  end

  // Second level: OR of the group registers.
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NG; g++) begin
      rd_word = rd_word | grp_q[g];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ok    <= ok;
      s1_read  <= (req.req_type == REQ_READ);
      s1_count <= live_count_next;
    end
  end

  // Output register; it holds its transaction until rsp_ready is seen.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      rsp.ok         <= s1_ok;
      rsp.read_value <= (s1_read && s1_ok) ? $signed(rd_word) : '0;
      rsp.count      <= s1_count;
    end
  end

endmodule

>>> hdl/bal_chk.sv
module bal_chk (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input bal_pkg::req_t              req,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input bal_pkg::rsp_t              rsp
);
  import bal_pkg::*;

  // A stalled result transaction keeps its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // A waiting request transaction keeps its payload until it is taken.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_ready |=> req_valid && $stable(req))
    else $error("request changed while waiting");

  // Reset leaves no result pending and the request side open.
  a_reset: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("state after reset is wrong");

  // Requests are only held off while a result waits on the receiver.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rsp_valid && !rsp_ready)
    else $error("request side blocked without a stalled result");

  // A word is only returned by a successful request.
  a_read_ok: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.read_value != '0) |-> rsp.ok)
    else $error("read data on a rejected request");

endmodule

bind bounded_array_list bal_chk u_bal_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
